/* design/apcr_pkg.sv */
// apcr_pkg: shared types, widths and codes for the acceptor pulse credit relay
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package apcr_pkg;

	localparam int COUNT_WIDTH = 8;
	localparam int TIMER_WIDTH = 20;
	localparam int MS_WIDTH    = 16;
	localparam int LEVEL_WIDTH = 10;
	localparam int HOLD_WIDTH  = 20;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [COUNT_WIDTH-2:0] credits_t;
	typedef logic [TIMER_WIDTH-1:0] timer_t;
	typedef logic [MS_WIDTH-1:0]    ms_t;
	typedef logic [LEVEL_WIDTH-1:0] level_t;
	typedef logic [HOLD_WIDTH-1:0]  hold_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

	localparam count_t COUNT_MAX = '1;
	localparam timer_t TIMER_MAX = '1;
	localparam ms_t    MS_MAX    = '1;

	// register indexes on the configuration port
	localparam cfg_idx_t CFG_AUDIO_TRIGGER_LEVEL = 3'd0;
	localparam cfg_idx_t CFG_START_PRESS_LEVEL   = 3'd1;
	localparam cfg_idx_t CFG_COIN_DEBOUNCE_MS    = 3'd2;
	localparam cfg_idx_t CFG_SETTLE_MS           = 3'd3;
	localparam cfg_idx_t CFG_PULSE_MS            = 3'd4;
	localparam cfg_idx_t CFG_MIC_CREDIT_HOLD_MS  = 3'd5;
	localparam cfg_idx_t CFG_AUDIO_HOLD_MS       = 3'd6;

	// register reset values
	localparam level_t RST_AUDIO_TRIGGER_LEVEL = 10'd150;
	localparam level_t RST_START_PRESS_LEVEL   = 10'd900;
	localparam ms_t    RST_COIN_DEBOUNCE_MS    = 16'd400;
	localparam ms_t    RST_SETTLE_MS           = 16'd1000;
	localparam ms_t    RST_PULSE_MS            = 16'd100;
	localparam hold_t  RST_MIC_CREDIT_HOLD_MS  = 20'd120000;
	localparam hold_t  RST_AUDIO_HOLD_MS       = 20'd120000;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEAD,
		PH_HIGH,
		PH_LOW
	} emit_phase_t;

	typedef struct packed {
		logic   bill_edge;
		logic   coin_edge;
		level_t audio_level;
		level_t start_level;
	} tick_t;

	typedef struct packed {
		logic credit_out;
		logic mic_enable;
	} relay_out_t;

endpackage

`default_nettype wire

/* design/apcr_tick_if.sv */
// apcr_tick_if / apcr_out_if: valid/ready channels for tick items and results
// depends on apcr_pkg for the payload structs
`default_nettype none

interface apcr_tick_if;
	logic           valid;
	logic           ready;
	apcr_pkg::tick_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface apcr_out_if;
	logic                valid;
	logic                ready;
	apcr_pkg::relay_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/acceptor_pulse_credit_relay.sv */
// acceptor_pulse_credit_relay: coin/bill pulse counter, credit pulse relay, mic enable
// depends on apcr_pkg and the channel interfaces in apcr_tick_if.sv
//
// Usage: each transfer on "items" is one 1 ms tick carrying the bill and coin
// edges and two ADC samples. Each tick yields exactly one transfer on
// "results" with the credit line level and the mic enable for that tick. Registers
// are written through cfg_we/cfg_idx/cfg_data by the user only while no tick is in
// flight; the block does not enforce it. Indexes above the last register are ignored.
// Flow: a tick is captured in the input stage; the step that takes it
// updates all state and loads the result register, which offers the
// result on results until it is taken.
// Throughput: one tick per cycle while results.ready stays high; the state
// update is a single pass of counters and compares between the two stages.
// Stall: when results.ready is low the result register holds, the input
// stage holds one more tick, then items.ready drops; nothing is lost.
// Reset (arst_n low): counters, timers and flags clear, the sequencer goes
// idle, registers return to their defaults and both stages empty.
`default_nettype none

module acceptor_pulse_credit_relay (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	apcr_tick_if.sink                 items,
	apcr_out_if.source                results,
	input  wire logic                 cfg_we,
	input  wire apcr_pkg::cfg_idx_t   cfg_idx,
	input  wire apcr_pkg::cfg_data_t  cfg_data
);

	// configuration registers
	apcr_pkg::level_t audio_trig_q;
	apcr_pkg::level_t start_lvl_q;
	apcr_pkg::ms_t    coin_deb_q;
	apcr_pkg::ms_t    settle_q;
	apcr_pkg::ms_t    pulse_q;
	apcr_pkg::hold_t  credit_hold_q;
	apcr_pkg::hold_t  audio_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_trig_q  <= apcr_pkg::RST_AUDIO_TRIGGER_LEVEL;
			start_lvl_q   <= apcr_pkg::RST_START_PRESS_LEVEL;
			coin_deb_q    <= apcr_pkg::RST_COIN_DEBOUNCE_MS;
			settle_q      <= apcr_pkg::RST_SETTLE_MS;
			pulse_q       <= apcr_pkg::RST_PULSE_MS;
			credit_hold_q <= apcr_pkg::RST_MIC_CREDIT_HOLD_MS;
			audio_hold_q  <= apcr_pkg::RST_AUDIO_HOLD_MS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				apcr_pkg::CFG_AUDIO_TRIGGER_LEVEL:
					audio_trig_q <= cfg_data[apcr_pkg::LEVEL_WIDTH-1:0];
				apcr_pkg::CFG_START_PRESS_LEVEL:
					start_lvl_q <= cfg_data[apcr_pkg::LEVEL_WIDTH-1:0];
				apcr_pkg::CFG_COIN_DEBOUNCE_MS:
					coin_deb_q <= cfg_data[apcr_pkg::MS_WIDTH-1:0];
				apcr_pkg::CFG_SETTLE_MS:
					settle_q <= cfg_data[apcr_pkg::MS_WIDTH-1:0];
				apcr_pkg::CFG_PULSE_MS:
					pulse_q <= cfg_data[apcr_pkg::MS_WIDTH-1:0];
				apcr_pkg::CFG_MIC_CREDIT_HOLD_MS:
					credit_hold_q <= cfg_data[apcr_pkg::HOLD_WIDTH-1:0];
				apcr_pkg::CFG_AUDIO_HOLD_MS:
					audio_hold_q <= cfg_data[apcr_pkg::HOLD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic            s1_valid;
	apcr_pkg::tick_t tick_s1;
	logic            out_valid_s2;
	logic            step;

	assign step        = s1_valid && (!out_valid_s2 || results.ready);
	assign items.ready = !s1_valid || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (items.ready)
				s1_valid <= items.valid;
			if (step)
				out_valid_s2 <= 1'b1;
			else if (results.ready)
				out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready)
			tick_s1 <= items.data;
	end

	// relay state
	apcr_pkg::count_t      pulse_count_q;
	apcr_pkg::ms_t         since_check_q;
	apcr_pkg::ms_t         since_coin_q;
	apcr_pkg::credits_t    credits_left_q;
	apcr_pkg::emit_phase_t emit_phase_q;
	apcr_pkg::ms_t         phase_ms_q;
	logic                  keep_one_q;
	apcr_pkg::timer_t      credit_timer_q;
	apcr_pkg::timer_t      audio_timer_q;
	logic                  credit_armed_q;
	logic                  audio_active_q;
	logic                  start_pressed_q;

	apcr_pkg::count_t      pulse_count_d;
	apcr_pkg::ms_t         since_check_d;
	apcr_pkg::ms_t         since_coin_d;
	apcr_pkg::credits_t    credits_left_d;
	apcr_pkg::emit_phase_t emit_phase_d;
	apcr_pkg::ms_t         phase_ms_d;
	logic                  keep_one_d;
	apcr_pkg::timer_t      credit_timer_d;
	apcr_pkg::timer_t      audio_timer_d;
	logic                  credit_armed_d;
	logic                  audio_active_d;
	logic                  start_pressed_d;
	apcr_pkg::ms_t         pulse_len;
	logic                  phase_done;
	logic                  finish;

	assign pulse_len = (pulse_q == '0) ? apcr_pkg::ms_t'(1) : pulse_q;

	// next state for one tick
	always_comb begin
		since_check_d   = (since_check_q == apcr_pkg::MS_MAX) ? since_check_q
			: since_check_q + 1'b1;
		since_coin_d    = (since_coin_q == apcr_pkg::MS_MAX) ? since_coin_q
			: since_coin_q + 1'b1;
		credit_timer_d  = (credit_timer_q == apcr_pkg::TIMER_MAX) ? credit_timer_q
			: credit_timer_q + 1'b1;
		audio_timer_d   = (audio_timer_q == apcr_pkg::TIMER_MAX) ? audio_timer_q
			: audio_timer_q + 1'b1;
		pulse_count_d   = pulse_count_q;
		credits_left_d  = credits_left_q;
		emit_phase_d    = emit_phase_q;
		phase_ms_d      = phase_ms_q;
		keep_one_d      = keep_one_q;
		credit_armed_d  = credit_armed_q;
		audio_active_d  = audio_active_q;
		start_pressed_d = start_pressed_q;
		phase_done      = 1'b0;
		finish          = 1'b0;

		if (emit_phase_q == apcr_pkg::PH_IDLE) begin
			if (tick_s1.bill_edge) begin
				if (pulse_count_d != apcr_pkg::COUNT_MAX)
					pulse_count_d = pulse_count_d + 1'b1;
				since_check_d = '0;
			end
			if (tick_s1.coin_edge && (since_coin_d > coin_deb_q)) begin
				if (pulse_count_d != apcr_pkg::COUNT_MAX)
					pulse_count_d = pulse_count_d + 1'b1;
				since_check_d = '0;
				since_coin_d  = '0;
			end
			if (since_check_d > settle_q) begin
				since_check_d = '0;
				if (pulse_count_d > apcr_pkg::count_t'(1)) begin
					credits_left_d = pulse_count_d[apcr_pkg::COUNT_WIDTH-1:1];
					keep_one_d     = pulse_count_d[0];
					emit_phase_d   = apcr_pkg::PH_LEAD;
					phase_ms_d     = '0;
				end
			end
		end else begin
			phase_ms_d = (phase_ms_q == apcr_pkg::MS_MAX) ? phase_ms_q
				: phase_ms_q + 1'b1;
			phase_done = (phase_ms_d >= pulse_len);
			if (phase_done) begin
				phase_ms_d = '0;
				unique case (emit_phase_q)
					apcr_pkg::PH_LEAD: begin
						if (credits_left_q != '0)
							emit_phase_d = apcr_pkg::PH_HIGH;
						else
							finish = 1'b1;
					end
					apcr_pkg::PH_HIGH: emit_phase_d = apcr_pkg::PH_LOW;
					default: begin
						// end of a low phase: one credit delivered
						if (credits_left_d != '0)
							credits_left_d = credits_left_d - 1'b1;
						credit_armed_d = 1'b1;
						credit_timer_d = '0;
						if (credits_left_d != '0)
							emit_phase_d = apcr_pkg::PH_HIGH;
						else if (keep_one_q)
							emit_phase_d = apcr_pkg::PH_LEAD;
						else
							finish = 1'b1;
					end
				endcase
				if (finish) begin
					pulse_count_d  = apcr_pkg::count_t'(keep_one_q);
					keep_one_d     = 1'b0;
					credits_left_d = '0;
					emit_phase_d   = apcr_pkg::PH_IDLE;
				end
			end
		end

		if (tick_s1.audio_level > audio_trig_q) begin
			audio_active_d  = 1'b1;
			start_pressed_d = 1'b0;
			audio_timer_d   = '0;
		end
		if (tick_s1.start_level < start_lvl_q)
			start_pressed_d = 1'b1;
		if (32'(credit_timer_d) > 32'(credit_hold_q)) begin
			credit_armed_d  = 1'b0;
			start_pressed_d = 1'b0;
		end
		if (32'(audio_timer_d) > 32'(audio_hold_q))
			audio_active_d = 1'b0;
	end

	// result for this tick
	apcr_pkg::relay_out_t result_d;
	apcr_pkg::relay_out_t result_s2;

	always_comb begin
		result_d.credit_out = (emit_phase_d == apcr_pkg::PH_HIGH);
		result_d.mic_enable = (credit_armed_d && start_pressed_d) || audio_active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_count_q   <= '0;
			since_check_q   <= '0;
			since_coin_q    <= '0;
			credits_left_q  <= '0;
			emit_phase_q    <= apcr_pkg::PH_IDLE;
			phase_ms_q      <= '0;
			keep_one_q      <= 1'b0;
			credit_timer_q  <= '0;
			audio_timer_q   <= '0;
			credit_armed_q  <= 1'b0;
			audio_active_q  <= 1'b0;
			start_pressed_q <= 1'b0;
		end else if (step) begin
			pulse_count_q   <= pulse_count_d;
			since_check_q   <= since_check_d;
			since_coin_q    <= since_coin_d;
			credits_left_q  <= credits_left_d;
			emit_phase_q    <= emit_phase_d;
			phase_ms_q      <= phase_ms_d;
			keep_one_q      <= keep_one_d;
			credit_timer_q  <= credit_timer_d;
			audio_timer_q   <= audio_timer_d;
			credit_armed_q  <= credit_armed_d;
			audio_active_q  <= audio_active_d;
			start_pressed_q <= start_pressed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			result_s2 <= result_d;
	end

	assign results.valid = out_valid_s2;
	assign results.data  = result_s2;

	// a high phase is only entered with a credit still to deliver
	a_high_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_phase_q == apcr_pkg::PH_HIGH |-> credits_left_q != '0)
		else $error("credit pulse high with no credit left");

	// idle sequencer leaves nothing behind
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		emit_phase_q == apcr_pkg::PH_IDLE |-> credits_left_q == '0 && !keep_one_q)
		else $error("idle with leftover credits or kept pulse");

	// the count is frozen while credits are being sent
	a_count_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit_phase_q != apcr_pkg::PH_IDLE && emit_phase_d != apcr_pkg::PH_IDLE
		|=> $stable(pulse_count_q))
		else $error("pulse count moved during emission");

	// a held tick stays in the input stage until it is processed
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !step |=> s1_valid)
		else $error("tick dropped from input stage");

endmodule

`default_nettype wire
